@@ src/mm4_pkg.sv @@
`timescale 1ns / 1ps

package mm4_pkg;

	// Element word: signed fixed point, fraction width set on the top level
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	// Saturation limits of the result word
	localparam word_t SAT_POS = 32'sh7FFF_FFFF;
	localparam word_t SAT_NEG = 32'sh8000_0000;

	// Exact product of two element words
	localparam int PROD_W = 2 * WORD_W;

	typedef logic signed [PROD_W-1:0] prod_t;

endpackage

@@ src/matrix4_multiply_core.sv @@
`timescale 1ns / 1ps

// Square matrix multiplier in signed fixed point. Each input transaction writes one
// left and one right element at a row-major index; an index past the matrix is
// dropped, and the final index (MATRIX_DIM*MATRIX_DIM-1) also starts the multiply
// on the current store contents. Loading takes one transaction per cycle while no
// multiply runs. A multiply runs on one shared 32x32 multiplier fed by one read port
// per store: for each result element the sequencer issues MATRIX_DIM reads, then waits
// for the products to pass the read, multiply and accumulate registers and for the
// output register to be free, so a stall on the result side holds the run. s_tready is
// low during a run. Dot products are summed exactly, shifted right by FRAC_BITS
// (rounding toward minus infinity) and saturated to 32 bits; tuser flags a saturated
// element and tlast marks the last element. Stores hold garbage until written.
module matrix4_multiply_core #(
	parameter int MATRIX_DIM = 4,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// fields from bit 0: element_index, left_value, right_value, zero pad
	input  logic [((($clog2(MATRIX_DIM*MATRIX_DIM) + 2*mm4_pkg::WORD_W) + 7) / 8) * 8 - 1:0]
		s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// fields from bit 0: row, column, product_value, zero pad
	output logic [(((2*$clog2(MATRIX_DIM) + mm4_pkg::WORD_W) + 7) / 8) * 8 - 1:0] m_tdata,
	// fields from bit 0: clipped
	output logic m_tuser,
	// last_of_run
	output logic m_tlast
);

	localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
	localparam int IDX_W  = $clog2(CELLS);
	localparam int RC_W   = $clog2(MATRIX_DIM);
	localparam int IN_W   = ((IDX_W + 2*mm4_pkg::WORD_W + 7) / 8) * 8;
	localparam int OUT_W  = ((2*RC_W + mm4_pkg::WORD_W + 7) / 8) * 8;
	localparam int ACC_W  = mm4_pkg::PROD_W + RC_W + 1;
	localparam int IPAD_W = IN_W - IDX_W - 2*mm4_pkg::WORD_W;
	localparam int OPAD_W = OUT_W - 2*RC_W - mm4_pkg::WORD_W;

	localparam logic [IDX_W:0]   CELLS_V  = (IDX_W+1)'(CELLS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);
	localparam logic [RC_W-1:0]  LAST_RC  = RC_W'(MATRIX_DIM - 1);

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	logic [1:0] st_q;

	// Input fields
	logic [IDX_W-1:0]     in_idx;
	mm4_pkg::word_t       in_left;
	mm4_pkg::word_t       in_right;
	logic                 in_acc;
	logic                 in_valid_idx;

	assign in_idx       = s_tdata[IDX_W-1:0];
	assign in_left      = s_tdata[IDX_W +: mm4_pkg::WORD_W];
	assign in_right     = s_tdata[IDX_W + mm4_pkg::WORD_W +: mm4_pkg::WORD_W];
	assign s_tready     = (st_q == ST_IDLE);
	assign in_acc       = s_tvalid && s_tready;
	assign in_valid_idx = ({1'b0, in_idx} < CELLS_V);

	// Element stores
	mm4_pkg::word_t left_mem  [CELLS];
	mm4_pkg::word_t right_mem [CELLS];

	// Loop counters: result row, result column, dot product step
	logic [RC_W-1:0] r_q, c_q, k_q;

	logic [IDX_W-1:0] left_addr, right_addr;
	logic             rd_en;

	assign left_addr  = IDX_W'(int'(r_q) * MATRIX_DIM + int'(k_q));
	assign right_addr = IDX_W'(int'(k_q) * MATRIX_DIM + int'(c_q));
	assign rd_en      = (st_q == ST_ISSUE);

	// Store write and registered read
	mm4_pkg::word_t left_rd_s1, right_rd_s1;

	always_ff @(posedge clk) begin
		if (in_acc && in_valid_idx) begin
			left_mem[in_idx]  <= in_left;
			right_mem[in_idx] <= in_right;
		end
		if (rd_en) begin
			left_rd_s1  <= left_mem[left_addr];
			right_rd_s1 <= right_mem[right_addr];
		end
	end

	// Multiply-accumulate pipeline valid and final-step flags
	logic vld_s1, vld_s2, lastk_s1, lastk_s2;
	mm4_pkg::prod_t mul_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic acc_done_q;

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			mul_s2 <= left_rd_s1 * right_rd_s1;
		end
	end

	// Saturation of the shifted sum
	logic signed [ACC_W-1:0] acc_sh;
	logic [ACC_W-mm4_pkg::WORD_W:0] acc_hi;
	logic acc_fits;
	mm4_pkg::word_t sat_val;

	always_comb begin
		acc_sh   = acc_q >>> FRAC_BITS;
		acc_hi   = acc_sh[ACC_W-1:mm4_pkg::WORD_W-1];
		acc_fits = (&acc_hi) || !(|acc_hi);
		if (acc_fits) begin
			sat_val = acc_sh[mm4_pkg::WORD_W-1:0];
		end else if (acc_sh[ACC_W-1]) begin
			sat_val = mm4_pkg::SAT_NEG;
		end else begin
			sat_val = mm4_pkg::SAT_POS;
		end
	end

	// Output register load
	logic out_free, load_out;

	assign out_free = !m_tvalid || m_tready;
	assign load_out = (st_q == ST_WAIT) && acc_done_q && out_free;

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= {{OPAD_W{1'b0}}, sat_val, c_q, r_q};
			m_tuser <= !acc_fits;
			m_tlast <= (r_q == LAST_RC) && (c_q == LAST_RC);
		end
	end

	// Sequencer, pipeline control and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			lastk_s1   <= 1'b0;
			lastk_s2   <= 1'b0;
			acc_done_q <= 1'b0;
			acc_q      <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			vld_s1   <= rd_en;
			lastk_s1 <= rd_en && (k_q == LAST_RC);
			vld_s2   <= vld_s1;
			lastk_s2 <= lastk_s1;

			if (load_out) begin
				acc_q      <= '0;
				acc_done_q <= 1'b0;
			end else if (vld_s2) begin
				acc_q <= acc_q + ACC_W'(mul_s2);
				if (lastk_s2) begin
					acc_done_q <= 1'b1;
				end
			end

			if (load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end

			case (st_q)
				ST_IDLE: begin
					if (in_acc && (in_idx == LAST_IDX)) begin
						r_q  <= '0;
						c_q  <= '0;
						k_q  <= '0;
						st_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_q == LAST_RC) begin
						k_q  <= '0;
						st_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (load_out) begin
						if (c_q == LAST_RC) begin
							c_q <= '0;
							if (r_q == LAST_RC) begin
								r_q  <= '0;
								st_q <= ST_IDLE;
							end else begin
								r_q  <= r_q + 1'b1;
								st_q <= ST_ISSUE;
							end
						end else begin
							c_q  <= c_q + 1'b1;
							st_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pad bits of the input word carry nothing
	logic unused_pad;
	assign unused_pad = ^{1'b0, s_tdata[IN_W-1 -: IPAD_W]};

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int DIM      = 4;
	localparam int FRAC     = 16;
	localparam int CELLS    = DIM * DIM;
	localparam int LAST_IDX = CELLS - 1;
	localparam int S_W      = ((4 + 2 * mm4_pkg::WORD_W + 7) / 8) * 8;
	localparam int M_W      = ((4 + mm4_pkg::WORD_W + 7) / 8) * 8;

	localparam int RUN_CYCLES  = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 90;

	typedef enum int {VAL_SMALL, VAL_MID, VAL_FULL, VAL_CORNER} val_mode_t;

	typedef struct {
		logic [3:0]     idx;
		mm4_pkg::word_t left;
		mm4_pkg::word_t right;
	} load_t;

	typedef struct {
		logic [1:0]     row;
		logic [1:0]     column;
		mm4_pkg::word_t value;
		logic           clipped;
		logic           last;
	} product_t;

	logic           clk      = 1'b0;
	logic           arst_n   = 1'b0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [S_W-1:0] s_tdata  = '0;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic           m_tuser;
	logic           m_tlast;

	// stimulus and expectations
	load_t          load_q[$];
	product_t       product_q[$];
	load_t          cur_load;
	mm4_pkg::word_t left_mat  [CELLS];
	mm4_pkg::word_t right_mat [CELLS];
	int             queued_total   = 0;
	int             accepted_total = 0;
	int             error_count    = 0;
	int             send_idle_pct  = 0;
	int             recv_stall_pct = 0;
	int             hold_left      = 0;
	logic           hold_kick      = 1'b0;

	matrix4_multiply_core #(
		.MATRIX_DIM(DIM),
		.FRAC_BITS (FRAC)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		if (error_count <= 50)
			$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
	endtask

	// Store one element pair; the final index multiplies the whole matrix
	function automatic void apply_load(load_t it);
		logic signed [127:0] acc;
		logic signed [127:0] shifted;
		mm4_pkg::prod_t      p;
		product_t            e;
		left_mat[it.idx]  = it.left;
		right_mat[it.idx] = it.right;
		if (it.idx != LAST_IDX)
			return;
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				acc = '0;
				for (int k = 0; k < DIM; k++) begin
					p   = left_mat[r * DIM + k] * right_mat[k * DIM + c];
					acc = acc + {{64{p[mm4_pkg::PROD_W-1]}}, p};
				end
				shifted   = acc >>> FRAC;
				e.row     = r[1:0];
				e.column  = c[1:0];
				e.clipped = 1'b1;
				if (shifted > mm4_pkg::SAT_POS)
					e.value = mm4_pkg::SAT_POS;
				else if (shifted < mm4_pkg::SAT_NEG)
					e.value = mm4_pkg::SAT_NEG;
				else begin
					e.value   = shifted[mm4_pkg::WORD_W-1:0];
					e.clipped = 1'b0;
				end
				e.last = (r == DIM - 1) && (c == DIM - 1);
				product_q.push_back(e);
			end
		end
	endfunction

	function automatic mm4_pkg::word_t rand_word(val_mode_t mode);
		mm4_pkg::word_t corner [6] = '{mm4_pkg::SAT_NEG, mm4_pkg::SAT_POS,
			32'sd0, 32'sd1, -32'sd1, 32'sh0001_0000};
		case (mode)
			VAL_SMALL: return mm4_pkg::word_t'(int'($urandom_range(262143)) - 131072);
			VAL_MID:   return mm4_pkg::word_t'(int'($urandom_range(33554431)) - 16777216);
			VAL_FULL:  return mm4_pkg::word_t'($urandom);
			default:   return corner[$urandom_range(5)];
		endcase
	endfunction

	task automatic queue_load(logic [3:0] idx, mm4_pkg::word_t left, mm4_pkg::word_t right);
		load_t it;
		it.idx   = idx;
		it.left  = left;
		it.right = right;
		load_q.push_back(it);
		queued_total++;
	endtask

	// One stimulus burst: full reload, partial update, stray single item or
	// stores with no multiply
	task automatic queue_batch(output int count);
		int         kind;
		int         n;
		int         pick;
		int         j;
		int         sw;
		logic [3:0] tmp;
		logic [3:0] order [LAST_IDX];
		val_mode_t  mode;
		kind = $urandom_range(9);
		pick = $urandom_range(99);
		mode = pick < 40 ? VAL_SMALL : pick < 70 ? VAL_MID : pick < 85 ? VAL_FULL : VAL_CORNER;
		for (j = 0; j < LAST_IDX; j++)
			order[j] = j[3:0];
		for (j = LAST_IDX - 1; j > 0; j--) begin
			sw        = $urandom_range(j);
			tmp       = order[j];
			order[j]  = order[sw];
			order[sw] = tmp;
		end
		if (kind <= 5)
			n = LAST_IDX;
		else if (kind == 8)
			n = 0;
		else
			n = $urandom_range(1, 6);
		count = 0;
		for (j = 0; j < n; j++) begin
			queue_load(order[j], rand_word(mode), rand_word(mode));
			count++;
		end
		if (kind <= 7) begin
			queue_load(4'(LAST_IDX), rand_word(mode), rand_word(mode));
			count++;
		end else if (kind == 8) begin
			queue_load(4'($urandom_range(LAST_IDX)), rand_word(mode), rand_word(mode));
			count++;
		end
	endtask

	task automatic drain();
		while (accepted_total != queued_total || product_q.size() != 0)
			@(posedge clk);
	endtask

	// Input driver: presents queued element pairs, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_load(cur_load);
				accepted_total++;
			end
			if (!s_tvalid || s_tready) begin
				if (load_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_load = load_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= S_W'({cur_load.right, cur_load.left, cur_load.idx});
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_kick)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Result monitor: compares each transaction with the oldest expected element
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (product_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata, 0);
				end else begin
					product_t e;
					e = product_q.pop_front();
					if (m_tdata[1:0] !== e.row)
						report_mismatch("row", m_tdata[1:0], e.row);
					if (m_tdata[3:2] !== e.column)
						report_mismatch("column", m_tdata[3:2], e.column);
					if (m_tdata[35:4] !== e.value)
						report_mismatch("product_value", m_tdata[35:4], e.value);
					if (m_tuser !== e.clipped)
						report_mismatch("clipped", m_tuser, e.clipped);
					if (m_tlast !== e.last)
						report_mismatch("last_of_run", m_tlast, e.last);
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Main sequence
	initial begin
		int got;
		int phase_items;
		int send_pct [4] = '{0, 76, 0, 37};
		int recv_pct [4] = '{0, 0, 76, 37};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: every index with extreme values, then repeated multiplies
		for (int i = 0; i < CELLS; i++)
			queue_load(4'(i), (i % 2) ? mm4_pkg::SAT_POS : mm4_pkg::SAT_NEG,
				(i % 3 == 0) ? mm4_pkg::SAT_NEG : mm4_pkg::SAT_POS);
		queue_load(4'(LAST_IDX), 32'sd0, 32'sd0);
		queue_load(4'(LAST_IDX), -32'sd1, 32'sd1);
		queue_load(4'(LAST_IDX), mm4_pkg::SAT_POS, mm4_pkg::SAT_POS);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			send_idle_pct  = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			phase_items    = 0;
			if (ph == 0) begin
				// back up the result side while loads keep coming
				while (phase_items < 40) begin
					queue_batch(got);
					phase_items += got;
				end
				@(posedge clk);
				hold_kick <= 1'b1;
				@(posedge clk);
				hold_kick <= 1'b0;
				@(negedge clk);
			end
			while (phase_items < PHASE_ITEMS) begin
				queue_batch(got);
				phase_items += got;
			end
			drain();
		end

		recv_stall_pct = 0;
		repeat (RUN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run limit
	initial begin
		#15000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
